@@ hw/rtl/crq_pkg.sv @@
// Shared types, constants and the helper function of the coalescing refresh queue.
package crq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int COORD_BITS  = 12;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int REMOVED_W   = 5;
  localparam int WAVE_W      = 8;
  localparam int MODE_W      = 2;
  localparam int STATUS_W    = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = COORD_BITS;

  localparam logic [COORD_BITS-1:0] FULL_TOLERANCE = COORD_BITS'(80);
  localparam logic [COORD_BITS-1:0] FAST_LIMIT     = COORD_BITS'(60);
  localparam logic [COORD_BITS:0]   FAST_SUM_LIMIT = (COORD_BITS + 1)'(40);

  localparam logic [COORD_BITS-1:0] SCREEN_WIDTH_RESET  = COORD_BITS'(1024);
  localparam logic [COORD_BITS-1:0] SCREEN_HEIGHT_RESET = COORD_BITS'(768);

  localparam logic OP_SUBMIT = 1'b0;
  localparam logic OP_TAKE   = 1'b1;

  localparam logic [MODE_W-1:0] MODE_FAST_ALWAYS = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FAST_SMALL  = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PARTIAL_MODE     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FULL_WAVEFORM    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PARTIAL_WAVEFORM = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_FAST_WAVEFORM    = 3'd5;

  typedef enum logic [STATUS_W-1:0] {
    ST_QUEUED        = 3'd0,
    ST_COVERED       = 3'd1,
    ST_EMPTY_IGNORED = 3'd2,
    ST_FULL_DROPPED  = 3'd3,
    ST_DISPATCHED    = 3'd4,
    ST_QUEUE_EMPTY   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMPACT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] left;
    logic [COORD_BITS-1:0] top;
    logic [COORD_BITS-1:0] width;
    logic [COORD_BITS-1:0] height;
  } rect_t;

  // Ripples from the oldest cell toward the newest.
  typedef struct packed {
    logic shift;
    logic covered;
  } chain_t;

  // Handed from each cell to the next older one when the queue moves down.
  typedef struct packed {
    rect_t rect;
    logic  mark;
  } cell_data_t;

  typedef struct packed {
    logic scan;
    logic advance;
    logic append;
    logic occupied;
  } cell_ctrl_t;

  // Inclusive containment of b in a; both rectangles are non-empty.
  function automatic logic rect_holds(rect_t a, rect_t b);
    logic [COORD_BITS:0] ar;
    logic [COORD_BITS:0] ab;
    logic [COORD_BITS:0] br;
    logic [COORD_BITS:0] bb;
    ar = {1'b0, a.left} + {1'b0, a.width} - (COORD_BITS + 1)'(1);
    ab = {1'b0, a.top} + {1'b0, a.height} - (COORD_BITS + 1)'(1);
    br = {1'b0, b.left} + {1'b0, b.width} - (COORD_BITS + 1)'(1);
    bb = {1'b0, b.top} + {1'b0, b.height} - (COORD_BITS + 1)'(1);
    return (a.left <= b.left) && ({1'b0, b.left} <= ar) && (br <= ar) &&
           (a.top <= b.top) && ({1'b0, b.top} <= ab) && (bb <= ab);
  endfunction

endpackage

@@ hw/rtl/crq_cell.sv @@
// One queue slot: holds a rectangle, tests containment and shifts toward the head.
module crq_cell import crq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  rect_t      new_rect,
  input  chain_t     chain_in,
  output chain_t     chain_out,
  input  cell_data_t upper,
  output cell_data_t data
);

  rect_t rect;
  logic  mark;
  logic  new_holds_entry;
  logic  entry_holds_new;
  logic  move;

  assign new_holds_entry = rect_holds(new_rect, rect);
  assign entry_holds_new = rect_holds(rect, new_rect);

  // An entry that is itself removed cannot cover the new rectangle.
  assign chain_out.covered = chain_in.covered |
                             (ctrl.occupied & ~new_holds_entry & entry_holds_new);
  // A slot moves down when a removal mark sits at or below it.
  assign chain_out.shift   = chain_in.shift | mark;
  assign move              = ctrl.advance & chain_out.shift;

  always_ff @(posedge clk) begin
    if (move) begin
      rect <= upper.rect;
    end else if (ctrl.append) begin
      rect <= new_rect;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mark <= 1'b0;
    end else if (ctrl.scan) begin
      mark <= ctrl.occupied & new_holds_entry & ~chain_in.covered;
    end else if (move) begin
      mark <= upper.mark;
    end
  end

  assign data.rect = rect;
  assign data.mark = mark;

endmodule

@@ hw/rtl/coalescing_refresh_queue_core.sv @@
// Top level of the coalescing refresh queue: control, cell chain and dispatch logic.
// A take passes from idle straight to the finish state, which writes its word to the output register.
// A submit first marks the queued entries that it removes, then stays in the compact state until
// no mark is left and then moves to the finish state; the chain compacts one removed entry per cycle.
// A result word waiting in the output register holds off only the final step of the next item.
// Synchronous reset empties the queue, clears the removal marks and restores the register
// defaults; slot rectangles are left as they are and never read before being written.
module coalescing_refresh_queue_core import crq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   operation,
  input  logic [COORD_BITS-1:0]  rect_left,
  input  logic [COORD_BITS-1:0]  rect_top,
  input  logic [COORD_BITS-1:0]  rect_width,
  input  logic [COORD_BITS-1:0]  rect_height,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [STATUS_W-1:0]    status,
  output logic [COORD_BITS-1:0]  region_left,
  output logic [COORD_BITS-1:0]  region_top,
  output logic [COORD_BITS-1:0]  region_width,
  output logic [COORD_BITS-1:0]  region_height,
  output logic [WAVE_W-1:0]      waveform_code,
  output logic                   full_update,
  output logic [REMOVED_W-1:0]   removed_count
);

  state_t state;
  state_t state_next;

  logic [COORD_BITS-1:0] screen_width;
  logic [COORD_BITS-1:0] screen_height;
  logic [MODE_W-1:0]     partial_mode;
  logic [WAVE_W-1:0]     full_waveform;
  logic [WAVE_W-1:0]     partial_waveform;
  logic [WAVE_W-1:0]     fast_waveform;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] removed;
  logic             op_q;
  logic             empty_q;
  logic             covered_q;
  rect_t            new_rect_q;

  rect_t      in_rect;
  rect_t      cell_rect;
  logic       in_empty;
  logic       accept_in;
  logic       fire;
  logic       scan_en;
  logic       pop;
  logic       append_en;
  logic       advance;
  logic       any_mark;
  logic       queue_full;

  chain_t     chain [QUEUE_DEPTH+1];
  cell_data_t cdata [QUEUE_DEPTH+1];

  status_t               res_status;
  logic [COORD_BITS-1:0] res_left;
  logic [COORD_BITS-1:0] res_top;
  logic [COORD_BITS-1:0] res_width;
  logic [COORD_BITS-1:0] res_height;
  logic [WAVE_W-1:0]     res_wave;
  logic                  res_full;
  logic [CNT_W-1:0]      res_removed;

  rect_t                 head;
  logic                  tol_w;
  logic                  tol_h;
  logic                  widen;
  logic [COORD_BITS-1:0] disp_w;
  logic [COORD_BITS-1:0] disp_h;
  logic [COORD_BITS:0]   disp_sum;
  logic                  small_rect;
  logic                  fast;

  status_t               status_q;

  assign in_rect    = '{left: rect_left, top: rect_top, width: rect_width, height: rect_height};
  assign in_empty   = (rect_width == '0) || (rect_height == '0);
  assign accept_in  = in_valid & ~in_stall;
  assign queue_full = (count == CNT_W'(QUEUE_DEPTH));
  assign any_mark   = chain[QUEUE_DEPTH].shift;
  // During the scan the cells compare against the incoming word itself.
  assign cell_rect  = (state == S_IDLE) ? in_rect : new_rect_q;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width     <= SCREEN_WIDTH_RESET;
      screen_height    <= SCREEN_HEIGHT_RESET;
      partial_mode     <= '0;
      full_waveform    <= '0;
      partial_waveform <= '0;
      fast_waveform    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:     screen_width     <= cfg_data;
        REG_SCREEN_HEIGHT:    screen_height    <= cfg_data;
        REG_PARTIAL_MODE:     partial_mode     <= cfg_data[MODE_W-1:0];
        REG_FULL_WAVEFORM:    full_waveform    <= cfg_data[WAVE_W-1:0];
        REG_PARTIAL_WAVEFORM: partial_waveform <= cfg_data[WAVE_W-1:0];
        REG_FAST_WAVEFORM:    fast_waveform    <= cfg_data[WAVE_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept_in) begin
          state_next = (operation == OP_SUBMIT) ? S_COMPACT : S_FINISH;
        end
      end
      S_COMPACT: begin
        if (!any_mark) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (fire) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_stall  = (state != S_IDLE);
    fire      = (state == S_FINISH) & (~out_valid | ~out_stall);
    scan_en   = accept_in & (operation == OP_SUBMIT) & ~in_empty;
    pop       = fire & (op_q == OP_TAKE) & (count != '0);
    append_en = fire & (op_q == OP_SUBMIT) & ~empty_q & ~covered_q & ~queue_full;
    advance   = (state == S_COMPACT) | pop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      removed <= '0;
    end else begin
      if (accept_in) begin
        removed <= '0;
      end else if ((state == S_COMPACT) && any_mark) begin
        removed <= removed + CNT_W'(1);
      end
      priority if ((state == S_COMPACT) && any_mark) begin
        count <= count - CNT_W'(1);
      end else if (pop) begin
        count <= count - CNT_W'(1);
      end else if (append_en) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      op_q       <= operation;
      empty_q    <= in_empty;
      covered_q  <= scan_en & chain[QUEUE_DEPTH].covered;
      new_rect_q <= in_rect;
    end
  end

  // Cell chain: slot 0 is the oldest entry.
  assign chain[0].shift         = pop;
  assign chain[0].covered       = 1'b0;
  assign cdata[QUEUE_DEPTH]     = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_ctrl_t ctrl;
    assign ctrl.scan     = scan_en;
    assign ctrl.advance  = advance;
    assign ctrl.append   = append_en & (count == CNT_W'(i));
    assign ctrl.occupied = (CNT_W'(i) < count);

    crq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .new_rect  (cell_rect),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .upper     (cdata[i+1]),
      .data      (cdata[i])
    );
  end

  // Dispatch of the head entry: widening and waveform choice.
  assign head     = cdata[0].rect;
  assign tol_w    = (screen_width < FULL_TOLERANCE) ||
                    (head.width >= (screen_width - FULL_TOLERANCE));
  assign tol_h    = (screen_height < FULL_TOLERANCE) ||
                    (head.height >= (screen_height - FULL_TOLERANCE));
  assign widen    = tol_w & tol_h;
  assign disp_w   = widen ? screen_width : head.width;
  assign disp_h   = widen ? screen_height : head.height;
  assign disp_sum = {1'b0, disp_w} + {1'b0, disp_h};
  assign small_rect = ((disp_w < FAST_LIMIT) && (disp_h < FAST_LIMIT)) ||
                      (disp_sum < FAST_SUM_LIMIT);
  assign fast     = (partial_mode == MODE_FAST_ALWAYS) ||
                    ((partial_mode == MODE_FAST_SMALL) && small_rect);

  always_comb begin
    res_status  = ST_QUEUED;
    res_left    = '0;
    res_top     = '0;
    res_width   = '0;
    res_height  = '0;
    res_wave    = '0;
    res_full    = 1'b0;
    res_removed = '0;
    if (op_q == OP_TAKE) begin
      if (count == '0) begin
        res_status = ST_QUEUE_EMPTY;
      end else begin
        res_status = ST_DISPATCHED;
        res_left   = widen ? '0 : head.left;
        res_top    = widen ? '0 : head.top;
        res_width  = disp_w;
        res_height = disp_h;
        res_wave   = widen ? full_waveform : (fast ? fast_waveform : partial_waveform);
        res_full   = widen;
      end
    end else if (empty_q) begin
      res_status = ST_EMPTY_IGNORED;
    end else begin
      res_removed = removed;
      priority if (covered_q) begin
        res_status = ST_COVERED;
      end else if (queue_full) begin
        res_status = ST_FULL_DROPPED;
      end else begin
        res_status = ST_QUEUED;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_q      <= res_status;
      region_left   <= res_left;
      region_top    <= res_top;
      region_width  <= res_width;
      region_height <= res_height;
      waveform_code <= res_wave;
      full_update   <= res_full;
      removed_count <= REMOVED_W'(res_removed);
    end
  end

  assign status = status_q;

endmodule

@@ hw/rtl/crq_checker.sv @@
// Port-level assertions for the coalescing refresh queue, bound to the top level.
module crq_checker import crq_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [STATUS_W-1:0]   status,
  input logic [COORD_BITS-1:0] region_left,
  input logic [COORD_BITS-1:0] region_top,
  input logic [COORD_BITS-1:0] region_width,
  input logic [COORD_BITS-1:0] region_height,
  input logic [WAVE_W-1:0]     waveform_code,
  input logic                  full_update,
  input logic [REMOVED_W-1:0]  removed_count
);

  // A stalled result word keeps its status.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status))
    else $error("stalled result word changed");

  // The block works on one word at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while the previous word is still in work");

  // Only a dispatch carries a region.
  a_zero_unless_dispatch: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_DISPATCHED) |->
      region_left == '0 && region_top == '0 && region_width == '0 &&
      region_height == '0 && waveform_code == '0 && !full_update)
    else $error("region fields set on a word that is not a dispatch");

  // A full update always covers the screen from the origin.
  a_full_at_origin: assert property (@(posedge clk) disable iff (rst)
    out_valid && full_update |->
      status == ST_DISPATCHED && region_left == '0 && region_top == '0)
    else $error("full update not placed at the origin");

  // Takes and ignored submits never report removed entries.
  a_no_removal: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_DISPATCHED || status == ST_QUEUE_EMPTY ||
                  status == ST_EMPTY_IGNORED) |-> removed_count == '0)
    else $error("removal count reported on a word that removes nothing");

endmodule

bind coalescing_refresh_queue_core crq_checker u_crq_checker (.*);

@@ sim/tb_coalescing_refresh_queue_core.sv @@
// Self-checking testbench for coalescing_refresh_queue_core: random handshakes against a queue model.
module tb_coalescing_refresh_queue_core import crq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [MODE_W-1:0] MODE_NORMAL    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UNDEFINED = 2'd3;
  localparam int WIDEN_MARGIN = 80;
  localparam int SMALL_SIDE   = 60;
  localparam int SMALL_SUM    = 40;
  localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
  localparam int LONG_HOLD    = 400;

  typedef struct {
    logic  op;
    rect_t r;
  } refresh_op_t;

  typedef struct {
    status_t             st;
    rect_t               region;
    logic [WAVE_W-1:0]   wave;
    logic                full;
    logic [REMOVED_W-1:0] removed;
  } outcome_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   operation = 1'b0;
  logic [COORD_BITS-1:0]  rect_left = '0;
  logic [COORD_BITS-1:0]  rect_top = '0;
  logic [COORD_BITS-1:0]  rect_width = '0;
  logic [COORD_BITS-1:0]  rect_height = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [STATUS_W-1:0]    status;
  logic [COORD_BITS-1:0]  region_left;
  logic [COORD_BITS-1:0]  region_top;
  logic [COORD_BITS-1:0]  region_width;
  logic [COORD_BITS-1:0]  region_height;
  logic [WAVE_W-1:0]      waveform_code;
  logic                   full_update;
  logic [REMOVED_W-1:0]   removed_count;

  coalescing_refresh_queue_core dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .rect_left(rect_left), .rect_top(rect_top),
    .rect_width(rect_width), .rect_height(rect_height),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .region_left(region_left), .region_top(region_top),
    .region_width(region_width), .region_height(region_height),
    .waveform_code(waveform_code), .full_update(full_update),
    .removed_count(removed_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model of the rectangle queue and its registers.
  rect_t                 q_slot [QUEUE_DEPTH];
  int                    q_fill = 0;
  logic [COORD_BITS-1:0] scr_w = SCREEN_WIDTH_RESET;
  logic [COORD_BITS-1:0] scr_h = SCREEN_HEIGHT_RESET;
  logic [MODE_W-1:0]     upd_mode = MODE_NORMAL;
  logic [WAVE_W-1:0]     wave_full = '0;
  logic [WAVE_W-1:0]     wave_partial = '0;
  logic [WAVE_W-1:0]     wave_fast = '0;

  refresh_op_t ops_to_send [$];
  outcome_t    due_words [$];
  rect_t       recent_rects [$];
  refresh_op_t cur_op;
  bit          idle_on = 1'b1;
  bit          tx_next;
  int          tx_gap = 0;
  int          hold_left = 0;
  int          words_seen = 0;
  int          mismatches = 0;

  // Inclusive containment of b in a, both non-empty.
  function automatic bit encloses(rect_t a, rect_t b);
    int ar, ab, br, bb;
    ar = int'(a.left) + int'(a.width) - 1;
    ab = int'(a.top) + int'(a.height) - 1;
    br = int'(b.left) + int'(b.width) - 1;
    bb = int'(b.top) + int'(b.height) - 1;
    return a.left <= b.left && br <= ar && a.top <= b.top && bb <= ab;
  endfunction

  function automatic outcome_t coalesce_or_dispatch(refresh_op_t o);
    outcome_t res;
    rect_t    r;
    int       kept, removed;
    bit       covered, full, tiny, fast;
    kept = 0;
    removed = 0;
    covered = 1'b0;
    res.st = ST_QUEUED;
    res.region = '0;
    res.wave = '0;
    res.full = 1'b0;
    res.removed = '0;
    if (o.op == OP_SUBMIT) begin
      r = o.r;
      if (r.width == 0 || r.height == 0) begin
        res.st = ST_EMPTY_IGNORED;
        return res;
      end
      for (int i = 0; i < q_fill; i++) begin
        if (!covered && encloses(r, q_slot[i])) begin
          removed++;
          continue;
        end
        if (!covered && encloses(q_slot[i], r)) covered = 1'b1;
        q_slot[kept] = q_slot[i];
        kept++;
      end
      q_fill = kept;
      res.removed = REMOVED_W'(removed);
      if (covered) begin
        res.st = ST_COVERED;
      end else if (q_fill >= QUEUE_DEPTH) begin
        res.st = ST_FULL_DROPPED;
      end else begin
        q_slot[q_fill] = r;
        q_fill++;
      end
      return res;
    end
    if (q_fill == 0) begin
      res.st = ST_QUEUE_EMPTY;
      return res;
    end
    r = q_slot[0];
    for (int i = 1; i < q_fill; i++) q_slot[i-1] = q_slot[i];
    q_fill--;
    full = int'(r.width) >= int'(scr_w) - WIDEN_MARGIN &&
           int'(r.height) >= int'(scr_h) - WIDEN_MARGIN;
    if (full) begin
      r.left = '0;
      r.top = '0;
      r.width = scr_w;
      r.height = scr_h;
    end
    tiny = (int'(r.width) < SMALL_SIDE && int'(r.height) < SMALL_SIDE) ||
           (int'(r.width) + int'(r.height) < SMALL_SUM);
    fast = upd_mode == MODE_FAST_ALWAYS || (upd_mode == MODE_FAST_SMALL && tiny);
    res.st = ST_DISPATCHED;
    res.region = r;
    res.wave = full ? wave_full : (fast ? wave_fast : wave_partial);
    res.full = full;
    return res;
  endfunction

  function automatic rect_t box(int l, int t, int w, int h);
    rect_t r;
    r.left = COORD_BITS'(l);
    r.top = COORD_BITS'(t);
    r.width = COORD_BITS'(w);
    r.height = COORD_BITS'(h);
    return r;
  endfunction

  function automatic int clamp(int v, int lo);
    return v < lo ? lo : (v > COORD_MAX ? COORD_MAX : v);
  endfunction

  function automatic rect_t any_rect();
    return box($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
               $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
  endfunction

  // Rectangles are biased toward shapes that enclose or sit inside recent ones.
  function automatic rect_t pick_rect();
    rect_t r, base;
    int    sel, d, e, l, t, w, h;
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      r = any_rect();
    end else if (sel < 20) begin
      r = any_rect();
      if ($urandom_range(0, 1)) r.width = '0;
      else r.height = '0;
    end else if (sel < 32) begin
      d = $urandom_range(0, 1) ? $urandom_range(0, 4) - 82 : $urandom_range(0, 200) - 120;
      e = $urandom_range(0, 1) ? $urandom_range(0, 4) - 82 : $urandom_range(0, 200) - 120;
      r = box($urandom_range(0, 63), $urandom_range(0, 63),
              clamp(int'(scr_w) + d, 1), clamp(int'(scr_h) + e, 1));
    end else if (sel < 65 && recent_rects.size() != 0) begin
      base = recent_rects[$urandom_range(0, recent_rects.size() - 1)];
      d = $urandom_range(0, 8);
      e = $urandom_range(0, 8);
      if ($urandom_range(0, 1)) begin
        l = int'(base.left) + d;
        t = int'(base.top) + d;
        w = int'(base.width) - d - e;
        h = int'(base.height) - d - e;
      end else begin
        l = int'(base.left) - d;
        t = int'(base.top) - d;
        w = int'(base.width) + d + e;
        h = int'(base.height) + d + e;
      end
      r = box(clamp(l, 0), clamp(t, 0), clamp(w, 1), clamp(h, 1));
    end else begin
      r = box(16 * $urandom_range(0, 63), 16 * $urandom_range(0, 63),
              16 * $urandom_range(1, 16), 16 * $urandom_range(1, 16));
    end
    recent_rects.push_back(r);
    if (recent_rects.size() > 8) void'(recent_rects.pop_front());
    return r;
  endfunction

  task automatic push_op(logic op, rect_t r);
    refresh_op_t o;
    o.op = op;
    o.r = r;
    ops_to_send.push_back(o);
  endtask

  task automatic run_random_phase(int n, int take_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < take_pct) push_op(OP_TAKE, any_rect());
      else push_op(OP_SUBMIT, pick_rect());
    end
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_SCREEN_WIDTH:     scr_w = val;
      REG_SCREEN_HEIGHT:    scr_h = val;
      REG_PARTIAL_MODE:     upd_mode = val[MODE_W-1:0];
      REG_FULL_WAVEFORM:    wave_full = val[WAVE_W-1:0];
      REG_PARTIAL_WAVEFORM: wave_partial = val[WAVE_W-1:0];
      REG_FAST_WAVEFORM:    wave_fast = val[WAVE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_config(int sw, int sh, logic [MODE_W-1:0] mode,
                              int fw, int pw, int qw);
    write_reg(REG_SCREEN_WIDTH, CFG_DATA_W'(sw));
    write_reg(REG_SCREEN_HEIGHT, CFG_DATA_W'(sh));
    write_reg(REG_PARTIAL_MODE, CFG_DATA_W'(mode));
    write_reg(REG_FULL_WAVEFORM, CFG_DATA_W'(fw));
    write_reg(REG_PARTIAL_WAVEFORM, CFG_DATA_W'(pw));
    write_reg(REG_FAST_WAVEFORM, CFG_DATA_W'(qw));
    cfg_write <= 1'b0;
  endtask

  // Settled values are read at the falling edge.
  task automatic wait_idle();
    do @(negedge clk);
    while (ops_to_send.size() != 0 || in_valid || due_words.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      tx_next = in_valid;
      if (in_valid && !in_stall) begin
        due_words.push_back(coalesce_or_dispatch(cur_op));
        tx_next = 1'b0;
      end
      if (!tx_next) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (ops_to_send.size() != 0) begin
          cur_op = ops_to_send.pop_front();
          operation <= cur_op.op;
          rect_left <= cur_op.r.left;
          rect_top <= cur_op.r.top;
          rect_width <= cur_op.r.width;
          rect_height <= cur_op.r.height;
          tx_next = 1'b1;
          tx_gap = (idle_on && $urandom_range(0, 1)) ? $urandom_range(1, 16) : 0;
        end
      end
      in_valid <= tx_next;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_words.size() == 0) begin
          $display("%0t: result word with no expectation, status %0d", $time, status);
          mismatches++;
        end else begin
          check_field("status", due_words[0].st, status);
          check_field("region_left", due_words[0].region.left, region_left);
          check_field("region_top", due_words[0].region.top, region_top);
          check_field("region_width", due_words[0].region.width, region_width);
          check_field("region_height", due_words[0].region.height, region_height);
          check_field("waveform_code", due_words[0].wave, waveform_code);
          check_field("full_update", due_words[0].full, full_update);
          check_field("removed_count", due_words[0].removed, removed_count);
          void'(due_words.pop_front());
        end
        words_seen++;
        hold_left = (idle_on && $urandom_range(0, 1)) ? $urandom_range(1, 16) : 0;
        // Long hold-offs let the sender run into a full block.
        if (words_seen == 300 || words_seen == 1000) hold_left = LONG_HOLD;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_stall <= (hold_left != 0);
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    write_config(1024, 768, MODE_FAST_SMALL, 8'h01, 8'h02, 8'h03);

    push_op(OP_TAKE, box(0, 0, 0, 0));
    push_op(OP_SUBMIT, box(10, 10, 0, 20));
    push_op(OP_SUBMIT, box(10, 10, 20, 0));
    push_op(OP_SUBMIT, box(10, 10, 20, 20));
    push_op(OP_SUBMIT, box(10, 10, 20, 20));
    push_op(OP_SUBMIT, box(15, 15, 5, 5));
    push_op(OP_SUBMIT, box(0, 0, 100, 100));
    push_op(OP_SUBMIT, box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    push_op(OP_SUBMIT, box(0, 0, COORD_MAX, COORD_MAX));
    push_op(OP_TAKE, box(0, 0, 0, 0));
    // Three nested submits, all covered by the full-range entry that is still queued.
    push_op(OP_SUBMIT, box(100, 100, 10, 10));
    push_op(OP_SUBMIT, box(50, 50, 200, 200));
    push_op(OP_SUBMIT, box(90, 90, 30, 30));
    push_op(OP_TAKE, box(0, 0, 0, 0));
    push_op(OP_SUBMIT, box(5, 5, 59, 59));
    push_op(OP_TAKE, box(0, 0, 0, 0));
    push_op(OP_SUBMIT, box(0, 0, 1, 38));
    push_op(OP_TAKE, box(0, 0, 0, 0));
    push_op(OP_SUBMIT, box(0, 0, 60, 1));
    push_op(OP_TAKE, box(0, 0, 0, 0));
    push_op(OP_SUBMIT, box(3000, 2000, 944, 688));
    push_op(OP_TAKE, box(0, 0, 0, 0));
    push_op(OP_SUBMIT, box(1, 1, 943, 688));
    push_op(OP_TAKE, box(0, 0, 0, 0));
    push_op(OP_TAKE, box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    wait_idle();

    write_config(4095, 4095, MODE_NORMAL, 8'hFF, 8'h00, 8'h80);
    run_random_phase(240, 40);
    wait_idle();

    idle_on = 1'b0;
    write_config(1, 1, MODE_FAST_ALWAYS, 8'h00, 8'hFF, 8'h00);
    run_random_phase(240, 50);
    wait_idle();

    // Few takes, so the queue fills and submits get dropped.
    idle_on = 1'b1;
    write_config(320, 240, MODE_FAST_SMALL, 8'hAA, 8'h55, 8'h0F);
    run_random_phase(240, 10);
    wait_idle();

    write_config(79, 200, MODE_UNDEFINED, 8'h07, 8'h09, 8'h0B);
    run_random_phase(240, 55);
    wait_idle();

    write_config($urandom_range(1, 4095), $urandom_range(1, 4095),
                 MODE_W'($urandom_range(0, 3)), $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 255));
    run_random_phase(240, 35);
    wait_idle();

    idle_on = 1'b0;
    write_config(640, 480, MODE_FAST_SMALL, 8'hFE, 8'h01, 8'h7F);
    run_random_phase(240, 25);
    wait_idle();

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/crq_pkg.sv
hw/rtl/crq_cell.sv
hw/rtl/coalescing_refresh_queue_core.sv
hw/rtl/crq_checker.sv
sim/tb_coalescing_refresh_queue_core.sv
